// File: rtl/srfc_pkg.sv
// Shared types and constants for the sector ring flow controller.
// No dependencies; every other file in rtl uses this package by scoped name.
package srfc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_START_LBA      = 2'd0;
    localparam logic [1:0] CFG_SECTOR_COUNT   = 2'd1;
    localparam logic [1:0] CFG_DECRYPT_ENABLE = 2'd2;

    // input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_STREAM = 2'd1,
        PH_DRAIN  = 2'd2,
        PH_FINAL  = 2'd3
    } phase_t;

    typedef struct packed {
        logic kind;
        logic usb_tx_flag;
        logic emmc_gap_flag;
        logic emmc_done_flag;
    } in_item_t;

    typedef struct packed {
        logic        nak_endpoint;
        logic        ack_tx;
        logic        send_now;
        logic [7:0]  tx_slot;
        logic [15:0] send_index;
        logic        crypt_now;
        logic [7:0]  crypt_slot;
        logic [31:0] crypt_lba;
        logic        ack_emmc;
        logic [7:0]  next_fill_slot;
        logic        release_gap;
        logic        finished;
    } out_item_t;

    typedef struct packed {
        logic [31:0] start_lba;
        logic [15:0] sector_count;
        logic        decrypt_enable;
    } cfg_t;

endpackage

// File: rtl/srfc_core.sv
// Ring state registers and the per-transaction update logic.
// Depends on srfc_pkg.
module srfc_core #(
    parameter int RING_SLOTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  srfc_pkg::in_item_t  item,
    input  srfc_pkg::cfg_t      cfg,
    output srfc_pkg::out_item_t result
);

    localparam logic [15:0] LevelLimit = 16'(RING_SLOTS - 2);
    localparam logic [8:0]  SlotLimit  = 9'(RING_SLOTS);

    srfc_pkg::phase_t phase_reg, phase_next;
    logic [15:0] filled_reg, filled_next;
    logic [15:0] sent_reg, sent_next;
    logic [7:0]  fill_slot_reg, fill_slot_next;
    logic [7:0]  drain_slot_reg, drain_slot_next;
    logic        paused_reg, paused_next;
    logic        first_reg, first_next;

    function automatic logic [7:0] slot_after(input logic [7:0] s);
        logic [8:0] n;
        n = {1'b0, s} + 9'd1;
        return (n >= SlotLimit) ? 8'd0 : n[7:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= srfc_pkg::PH_IDLE;
            filled_reg     <= '0;
            sent_reg       <= '0;
            fill_slot_reg  <= '0;
            drain_slot_reg <= '0;
            paused_reg     <= 1'b0;
            first_reg      <= 1'b1;
        end else if (advance) begin
            phase_reg      <= phase_next;
            filled_reg     <= filled_next;
            sent_reg       <= sent_next;
            fill_slot_reg  <= fill_slot_next;
            drain_slot_reg <= drain_slot_next;
            paused_reg     <= paused_next;
            first_reg      <= first_next;
        end
    end

    always_comb begin
        logic        safe;
        logic [15:0] level;
        phase_next      = phase_reg;
        filled_next     = filled_reg;
        sent_next       = sent_reg;
        fill_slot_next  = fill_slot_reg;
        drain_slot_next = drain_slot_reg;
        paused_next     = paused_reg;
        first_next      = first_reg;
        result          = '0;
        safe            = (filled_reg > 16'd1) && (sent_reg < (filled_reg - 16'd1));
        level           = '0;

        if (item.kind == srfc_pkg::KIND_START) begin
            // restart: abort anything in flight silently
            phase_next      = srfc_pkg::PH_STREAM;
            filled_next     = '0;
            sent_next       = '0;
            fill_slot_next  = '0;
            drain_slot_next = '0;
            paused_next     = 1'b0;
            first_next      = 1'b1;
        end else begin
            case (phase_reg)
                srfc_pkg::PH_STREAM: begin
                    result.nak_endpoint = item.usb_tx_flag;
                    // send side first, one sector behind the fill side
                    if (safe && (item.usb_tx_flag || first_reg)) begin
                        result.ack_tx     = 1'b1;
                        result.send_now   = 1'b1;
                        result.tx_slot    = drain_slot_reg;
                        result.send_index = sent_reg;
                        first_next        = 1'b0;
                        sent_next         = sent_reg + 16'd1;
                        drain_slot_next   = slot_after(drain_slot_reg);
                        if (paused_reg) begin
                            paused_next        = 1'b0;
                            result.release_gap = 1'b1;
                        end
                    end
                    if (item.emmc_gap_flag || item.emmc_done_flag) begin
                        if (cfg.decrypt_enable) begin
                            result.crypt_now  = 1'b1;
                            result.crypt_slot = fill_slot_reg;
                            result.crypt_lba  = cfg.start_lba + {16'd0, filled_reg};
                        end
                        result.ack_emmc = 1'b1;
                        filled_next     = filled_reg + 16'd1;
                    end
                    if (item.emmc_gap_flag) begin
                        fill_slot_next        = slot_after(fill_slot_reg);
                        result.next_fill_slot = fill_slot_next;
                        level                 = filled_next - sent_next;
                        if (level < LevelLimit) begin
                            result.release_gap = 1'b1;
                        end else begin
                            paused_next = 1'b1;
                        end
                    end else if (item.emmc_done_flag) begin
                        // hold the fill slot on the last sector
                        result.next_fill_slot = fill_slot_reg;
                        phase_next            = srfc_pkg::PH_DRAIN;
                    end
                end
                srfc_pkg::PH_DRAIN: begin
                    if (sent_reg != filled_reg) begin
                        result.nak_endpoint = item.usb_tx_flag;
                        if (item.usb_tx_flag || first_reg) begin
                            result.ack_tx     = 1'b1;
                            result.send_now   = 1'b1;
                            result.tx_slot    = drain_slot_reg;
                            result.send_index = sent_reg;
                            first_next        = 1'b0;
                            sent_next         = sent_reg + 16'd1;
                            drain_slot_next   = slot_after(drain_slot_reg);
                        end
                        if (sent_next == filled_reg) begin
                            phase_next = srfc_pkg::PH_FINAL;
                        end
                    end else begin
                        phase_next = srfc_pkg::PH_FINAL;
                    end
                end
                default: begin
                end
            endcase

            // final send-complete ends the transfer
            if (phase_next == srfc_pkg::PH_FINAL && !result.send_now &&
                item.usb_tx_flag) begin
                result.nak_endpoint = 1'b1;
                result.ack_tx       = 1'b1;
                result.finished     = 1'b1;
                phase_next          = srfc_pkg::PH_IDLE;
            end
        end
    end

endmodule

// File: rtl/sector_ring_flow_controller.sv
// Top level: configuration registers, input register, result register.
// Depends on srfc_pkg and srfc_core.
//
//   port group     dir   handshake        payload
//   s_*            in    s_valid/s_ready  srfc_pkg::in_item_t  (one per transaction)
//   m_*            out   m_valid/m_ready  srfc_pkg::out_item_t (one per input)
//   cfg_*          in    cfg_wr_en        cfg_index, cfg_wr_data
//
// A transaction lands in the input register and its result is loaded into the result
// register once that is empty or being taken, which raises m_valid; one transaction per
// cycle is sustained while m_ready holds high, set by the single state update between
// the input and result registers. Reset (aresetn low, synchronous) empties both registers
// and clears the ring state and configuration. A stalled m_ready holds the result; the
// input register still takes one more transaction behind it.
module sector_ring_flow_controller #(
    parameter int RING_SLOTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srfc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srfc_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wr_data
);

    srfc_pkg::cfg_t      cfg_reg;
    srfc_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    srfc_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    srfc_pkg::out_item_t result;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srfc_pkg::CFG_START_LBA:      cfg_reg.start_lba      <= cfg_wr_data;
                srfc_pkg::CFG_SECTOR_COUNT:   cfg_reg.sector_count   <= cfg_wr_data[15:0];
                srfc_pkg::CFG_DECRYPT_ENABLE: cfg_reg.decrypt_enable <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    srfc_core #(
        .RING_SLOTS(RING_SLOTS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(advance),
        .item   (in_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule

// File: rtl/srfc_checker.sv
// Port-level checks on result transactions, bound to the top level.
// Depends on srfc_pkg and sector_ring_flow_controller.
module srfc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input srfc_pkg::out_item_t m_data
);

    // a send always acknowledges the USB flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.send_now |-> m_data.ack_tx)
        else $error("send without ack_tx");

    // the end of a transfer never carries a send
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.finished |->
            m_data.nak_endpoint && m_data.ack_tx && !m_data.send_now)
        else $error("bad finish result");

    // decrypt only for a sector the storage side just completed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.crypt_now |-> m_data.ack_emmc && !m_data.finished)
        else $error("crypt without ack_emmc");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.send_now |->
            m_data.tx_slot == 8'd0 && m_data.send_index == 16'd0)
        else $error("send fields set without send_now");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind sector_ring_flow_controller srfc_checker u_srfc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_data (m_data)
);
